>>> hdl/gmng_pkg.sv
package gmng_pkg;

    localparam int DIM_W      = 9;
    localparam int CFG_ADDR_W = 1;
    localparam int IDX_W      = 16;
    localparam int COORD_W    = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int NORM_W     = 36;

    localparam logic [DIM_W-1:0] DIM_RESET = 9'd16;

    localparam logic [CFG_ADDR_W-1:0] REG_DIM_X = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_DIM_Y = 1'b1;

    localparam logic KIND_NORMAL   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
        logic signed [COORD_W-1:0] vz;
    } in_beat_t;

    typedef struct packed {
        logic                      kind;
        logic signed [NORM_W-1:0]  nx;
        logic signed [NORM_W-1:0]  ny;
        logic signed [NORM_W-1:0]  nz;
        logic        [IDX_W-1:0]   vertex_index;
        logic        [IDX_W-1:0]   corner_a;
        logic        [IDX_W-1:0]   corner_b;
        logic        [IDX_W-1:0]   corner_c;
        logic                      last;
    } out_beat_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] x;
        logic signed [DIFF_W-1:0] y;
        logic signed [DIFF_W-1:0] z;
    } dvec_t;

    typedef struct packed {
        logic signed [NORM_W-1:0] x;
        logic signed [NORM_W-1:0] y;
        logic signed [NORM_W-1:0] z;
    } nvec_t;

    // load enables of the product and sum stages of a cross unit
    typedef struct packed {
        logic prod_en;
        logic sum_en;
    } cross_en_t;

    function automatic dvec_t vdiff(in_beat_t a, in_beat_t b);
        dvec_t d;
        d.x = DIFF_W'(a.vx) - DIFF_W'(b.vx);
        d.y = DIFF_W'(a.vy) - DIFF_W'(b.vy);
        d.z = DIFF_W'(a.vz) - DIFF_W'(b.vz);
        return d;
    endfunction

endpackage

>>> hdl/gmng_cross.sv
module gmng_cross (
    input  logic                aclk,
    input  gmng_pkg::cross_en_t en,
    input  gmng_pkg::dvec_t     e1,
    input  gmng_pkg::dvec_t     e2,
    output gmng_pkg::nvec_t     n
);
    import gmng_pkg::*;

    logic signed [PROD_W-1:0] p_reg  [6];
    logic signed [PROD_W-1:0] p_next [6];
    nvec_t                    n_reg;

    always_comb begin
        p_next[0] = e1.y * e2.z;
        p_next[1] = e1.z * e2.y;
        p_next[2] = e1.z * e2.x;
        p_next[3] = e1.x * e2.z;
        p_next[4] = e1.x * e2.y;
        p_next[5] = e1.y * e2.x;
    end

    always_ff @(posedge aclk) begin
        if (en.prod_en) begin
            for (int k = 0; k < 6; k++) begin
                p_reg[k] <= p_next[k];
            end
        end
        if (en.sum_en) begin
            n_reg.x <= NORM_W'(p_reg[0]) - NORM_W'(p_reg[1]);
            n_reg.y <= NORM_W'(p_reg[2]) - NORM_W'(p_reg[3]);
            n_reg.z <= NORM_W'(p_reg[4]) - NORM_W'(p_reg[5]);
        end
    end

    assign n = n_reg;

endmodule

>>> hdl/grid_mesh_normal_generator.sv
// Grid mesh normal generator.
// s_* carries one vertex per beat, row-major over a dim_x by dim_y grid.
// m_* carries results: a vertex normal (kind 0, with its index) or a
// triangle (kind 1, three corner indices); last marks the final result
// caused by a vertex. The first row yields nothing; each later vertex
// yields one normal, plus two triangles past column 0; the last row adds
// the normals of that row. cfg_we writes dim_x (index 0) or dim_y (index 1)
// and restarts the grid; write only while idle.
// The first result of a vertex passes through stage 1, stage 2, the product
// and sum stages and the output register. Throughput: one vertex per cycle
// as long as the output keeps up; the single result port sets the rate, so a
// vertex with several results holds the input until it has given them all
// (1 in column 0, 3 elsewhere, 4 on the last row, 5 for the final vertex).
// The previous row sits in a one-row memory read one column ahead of the
// incoming vertex; three cross product units run in parallel.
// Reset (aresetn low, synchronous) empties the pipeline, sets both
// dimensions to 16 and starts a new grid. When m_ready is low, the
// pipeline fills up and then s_ready drops; no beat is lost.
module grid_mesh_normal_generator #(
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLUMNS = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [gmng_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [gmng_pkg::DIM_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  gmng_pkg::in_beat_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output gmng_pkg::out_beat_t                 m_data
);
    import gmng_pkg::*;

    localparam int COLW = $clog2(MAX_COLUMNS);
    localparam int ROWW = $clog2(MAX_ROWS);
    localparam int XW   = $clog2(MAX_ROWS + 1);
    localparam int YW   = $clog2(MAX_COLUMNS + 1);

    typedef struct packed {
        logic [IDX_W-1:0] p00;
        logic [IDX_W-1:0] p01;
        logic [IDX_W-1:0] p10;
        logic [IDX_W-1:0] p11;
    } idx_set_t;

    // configuration and position
    logic [DIM_W-1:0] dim_x_reg, dim_y_reg;
    logic [XW-1:0]    dx_eff;
    logic [YW-1:0]    dy_eff;
    logic [COLW-1:0]  col_reg;
    logic [ROWW-1:0]  row_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             last_col, last_row;
    logic [COLW-1:0]  rd_addr;

    // previous row, one column per entry
    in_beat_t         row_mem [MAX_COLUMNS];
    in_beat_t         rd_q_reg;

    // stage 1: raw neighbors
    logic             s1_valid_reg;
    in_beat_t         s1_cur_reg, s1_left_reg, s1_a_reg, s1_b_reg;
    logic             s1_i_ge1_reg, s1_j_ge1_reg, s1_last_col_reg, s1_last_row_reg;
    logic [IDX_W-1:0] s1_idx_reg;

    // stage 2: differences
    logic             s2_valid_reg;
    dvec_t            s2_n0e1_reg, s2_n0e2_reg, s2_ce1_reg, s2_n1e2_reg, s2_n2e2_reg;
    logic [4:0]       s2_mask_reg;
    idx_set_t         s2_idx_reg;

    // stages 3 and 4: products and sums live in the cross units
    logic             s3_valid_reg, s4_valid_reg;
    logic [4:0]       s3_mask_reg, s4_mask_reg;
    idx_set_t         s3_idx_reg, s4_idx_reg;

    logic             m_valid_reg;
    out_beat_t        m_data_reg;

    logic             adv1, adv2, adv3, adv4, accept;
    logic             emit, done4;
    logic [4:0]       pick, rest;
    out_beat_t        res;
    cross_en_t        cen;
    nvec_t            n0, n1, n2;
    logic [IDX_W-1:0] dy16, s1_up;

    always_comb begin
        if (dim_x_reg < DIM_W'(2)) begin
            dx_eff = XW'(2);
        end else if (32'(dim_x_reg) > MAX_ROWS) begin
            dx_eff = XW'(MAX_ROWS);
        end else begin
            dx_eff = XW'(dim_x_reg);
        end
        if (dim_y_reg < DIM_W'(2)) begin
            dy_eff = YW'(2);
        end else if (32'(dim_y_reg) > MAX_COLUMNS) begin
            dy_eff = YW'(MAX_COLUMNS);
        end else begin
            dy_eff = YW'(dim_y_reg);
        end
    end

    assign last_col = (YW'(col_reg) + YW'(1)) == dy_eff;
    assign last_row = (XW'(row_reg) + XW'(1)) == dx_eff;
    // read one column ahead; on the last column fetch column 0 for the next row
    assign rd_addr  = last_col ? '0 : col_reg + COLW'(1);

    // handshake chain
    assign pick  = s4_mask_reg & (~s4_mask_reg + 5'd1);
    assign rest  = s4_mask_reg & ~pick;
    assign emit  = s4_valid_reg && (s4_mask_reg != 5'd0) && (!m_valid_reg || m_ready);
    assign done4 = (s4_mask_reg == 5'd0) || (emit && (rest == 5'd0));
    assign adv4  = !s4_valid_reg || done4;
    assign adv3  = !s3_valid_reg || adv4;
    assign adv2  = !s2_valid_reg || adv3;
    assign adv1  = !s1_valid_reg || adv2;
    assign s_ready = adv1;
    assign accept  = s_valid && adv1;

    assign cen.prod_en = adv3;
    assign cen.sum_en  = adv4;

    gmng_cross u_cross0 (.aclk(aclk), .en(cen), .e1(s2_n0e1_reg), .e2(s2_n0e2_reg), .n(n0));
    gmng_cross u_cross1 (.aclk(aclk), .en(cen), .e1(s2_ce1_reg),  .e2(s2_n1e2_reg), .n(n1));
    gmng_cross u_cross2 (.aclk(aclk), .en(cen), .e1(s2_ce1_reg),  .e2(s2_n2e2_reg), .n(n2));

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_x_reg    <= DIM_RESET;
            dim_y_reg    <= DIM_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_DIM_X: dim_x_reg <= cfg_wdata;
                    REG_DIM_Y: dim_y_reg <= cfg_wdata;
                    default: ;
                endcase
                col_reg <= '0;
                row_reg <= '0;
                idx_reg <= '0;
            end else if (accept) begin
                if (last_col) begin
                    col_reg <= '0;
                    if (last_row) begin
                        row_reg <= '0;
                    end else begin
                        row_reg <= row_reg + ROWW'(1);
                    end
                end else begin
                    col_reg <= col_reg + COLW'(1);
                end
                idx_reg <= (last_col && last_row) ? '0 : idx_reg + IDX_W'(1);
            end
            if (adv1) s1_valid_reg <= s_valid;
            if (adv2) s2_valid_reg <= s1_valid_reg;
            if (adv3) s3_valid_reg <= s2_valid_reg;
            if (adv4) s4_valid_reg <= s3_valid_reg;
            if (!m_valid_reg || m_ready) m_valid_reg <= emit;
        end
    end

    // row memory and stage 1
    always_ff @(posedge aclk) begin
        if (accept) begin
            row_mem[col_reg] <= s_data;
            rd_q_reg         <= row_mem[rd_addr];
            s1_cur_reg       <= s_data;
            s1_left_reg      <= s1_cur_reg;
            s1_b_reg         <= rd_q_reg;
            s1_a_reg         <= s1_b_reg;
            s1_i_ge1_reg     <= row_reg != '0;
            s1_j_ge1_reg     <= col_reg != '0;
            s1_last_col_reg  <= last_col;
            s1_last_row_reg  <= last_row;
            s1_idx_reg       <= idx_reg;
        end
    end

    assign dy16  = IDX_W'(dy_eff);
    assign s1_up = s1_idx_reg - dy16;

    // stages 2 to 4 payload
    always_ff @(posedge aclk) begin
        if (adv2) begin
            // a: above-left, b: above, rd_q: above-right, left: same row
            s2_n0e1_reg <= s1_last_col_reg ? vdiff(s1_a_reg, s1_b_reg)
                                           : vdiff(s1_b_reg, rd_q_reg);
            s2_n0e2_reg <= vdiff(s1_b_reg, s1_cur_reg);
            s2_ce1_reg  <= vdiff(s1_left_reg, s1_cur_reg);
            s2_n1e2_reg <= vdiff(s1_a_reg, s1_left_reg);
            s2_n2e2_reg <= vdiff(s1_b_reg, s1_cur_reg);
            s2_mask_reg[0] <= s1_i_ge1_reg;
            s2_mask_reg[1] <= s1_i_ge1_reg && s1_j_ge1_reg;
            s2_mask_reg[2] <= s1_i_ge1_reg && s1_j_ge1_reg;
            s2_mask_reg[3] <= s1_i_ge1_reg && s1_last_row_reg && s1_j_ge1_reg;
            s2_mask_reg[4] <= s1_i_ge1_reg && s1_last_row_reg && s1_last_col_reg;
            s2_idx_reg.p11 <= s1_idx_reg;
            s2_idx_reg.p10 <= s1_idx_reg - IDX_W'(1);
            s2_idx_reg.p01 <= s1_up;
            s2_idx_reg.p00 <= s1_up - IDX_W'(1);
        end
        if (adv3) begin
            s3_mask_reg <= s2_mask_reg;
            s3_idx_reg  <= s2_idx_reg;
        end
        if (adv4) begin
            s4_mask_reg <= s3_mask_reg;
            s4_idx_reg  <= s3_idx_reg;
        end else if (emit) begin
            s4_mask_reg <= rest;
        end
        if (emit && (!m_valid_reg || m_ready)) begin
            m_data_reg <= res;
        end
    end

    // result picked by the lowest pending bit
    always_comb begin
        res      = '0;
        res.last = rest == 5'd0;
        if (s4_mask_reg[0]) begin
            res.kind         = KIND_NORMAL;
            res.nx           = n0.x;
            res.ny           = n0.y;
            res.nz           = n0.z;
            res.vertex_index = s4_idx_reg.p01;
        end else if (s4_mask_reg[1]) begin
            res.kind     = KIND_TRIANGLE;
            res.corner_a = s4_idx_reg.p00;
            res.corner_b = s4_idx_reg.p01;
            res.corner_c = s4_idx_reg.p10;
        end else if (s4_mask_reg[2]) begin
            res.kind     = KIND_TRIANGLE;
            res.corner_a = s4_idx_reg.p11;
            res.corner_b = s4_idx_reg.p01;
            res.corner_c = s4_idx_reg.p10;
        end else if (s4_mask_reg[3]) begin
            res.kind         = KIND_NORMAL;
            res.nx           = n1.x;
            res.ny           = n1.y;
            res.nz           = n1.z;
            res.vertex_index = s4_idx_reg.p10;
        end else begin
            res.kind         = KIND_NORMAL;
            res.nx           = n2.x;
            res.ny           = n2.y;
            res.nz           = n2.z;
            res.vertex_index = s4_idx_reg.p11;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import gmng_pkg::*;

    localparam int GRID_ROWS    = 256;
    localparam int GRID_COLS    = 256;
    localparam int SETTLE       = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT        = 1000000;
    localparam int RANDOM_ITEMS = 24;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [DIM_W-1:0]      cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_beat_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_beat_t             m_data;

    grid_mesh_normal_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // shadow of the block: grid size, last two rows, position of next vertex
    logic [DIM_W-1:0] dim_x_reg = DIM_RESET;
    logic [DIM_W-1:0] dim_y_reg = DIM_RESET;
    in_beat_t         row_mem [2][GRID_COLS];
    int unsigned      next_row = 0;
    int unsigned      next_col = 0;
    int unsigned      here_row;
    int unsigned      here_col;
    in_beat_t         here_vtx;

    in_beat_t         vertices_to_send [$];
    out_beat_t        results_due [$];

    int unsigned      src_level  = 0;
    int unsigned      sink_level = 0;
    int unsigned      src_wait   = 0;
    int unsigned      sink_wait  = 0;
    int unsigned      sink_gap;
    bit               hold_req   = 1'b0;
    bit               hold_done  = 1'b0;

    int unsigned      cycle_count    = 0;
    int unsigned      vertices_taken = 0;
    int unsigned      results_seen   = 0;
    int unsigned      normal_count   = 0;
    int unsigned      tri_count      = 0;
    int unsigned      mismatch_count = 0;
    int unsigned      grid_settings  = 0;
    int unsigned      random_sent    = 0;
    out_beat_t        want;
    bit               beat_bad;

    function automatic int unsigned span(logic [DIM_W-1:0] d, int unsigned top);
        if (d < 2) return 2;
        if (d > top) return top;
        return d;
    endfunction

    function automatic in_beat_t vertex_at(int unsigned r, int unsigned c);
        if (r == here_row && c == here_col) return here_vtx;
        return row_mem[r % 2][c % GRID_COLS];
    endfunction

    // forward differences inside the grid, backward on the last row / column
    function automatic out_beat_t normal_of(int unsigned r, int unsigned c,
                                            int unsigned dx, int unsigned dy);
        in_beat_t  a, b, p, q;
        longint    e1 [3];
        longint    e2 [3];
        longint    n [3];
        out_beat_t o;
        if (c + 1 < dy) begin
            a = vertex_at(r, c);
            b = vertex_at(r, c + 1);
        end else begin
            a = vertex_at(r, c - 1);
            b = vertex_at(r, c);
        end
        if (r + 1 < dx) begin
            p = vertex_at(r, c);
            q = vertex_at(r + 1, c);
        end else begin
            p = vertex_at(r - 1, c);
            q = vertex_at(r, c);
        end
        e1[0] = longint'($signed(a.vx)) - longint'($signed(b.vx));
        e1[1] = longint'($signed(a.vy)) - longint'($signed(b.vy));
        e1[2] = longint'($signed(a.vz)) - longint'($signed(b.vz));
        e2[0] = longint'($signed(p.vx)) - longint'($signed(q.vx));
        e2[1] = longint'($signed(p.vy)) - longint'($signed(q.vy));
        e2[2] = longint'($signed(p.vz)) - longint'($signed(q.vz));
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        o = '0;
        o.kind = KIND_NORMAL;
        o.nx = NORM_W'(n[0]);
        o.ny = NORM_W'(n[1]);
        o.nz = NORM_W'(n[2]);
        o.vertex_index = IDX_W'(r * dy + c);
        return o;
    endfunction

    function automatic out_beat_t triangle_of(int unsigned a, int unsigned b,
                                              int unsigned c);
        out_beat_t o;
        o = '0;
        o.kind = KIND_TRIANGLE;
        o.corner_a = IDX_W'(a);
        o.corner_b = IDX_W'(b);
        o.corner_c = IDX_W'(c);
        return o;
    endfunction

    function automatic void predict_vertex(in_beat_t v);
        int unsigned dx, dy, i, j, n;
        out_beat_t   res [5];
        dx = span(dim_x_reg, GRID_ROWS);
        dy = span(dim_y_reg, GRID_COLS);
        n = 0;
        if (next_row >= dx || next_col >= dy) begin
            next_row = 0;
            next_col = 0;
        end
        i = next_row;
        j = next_col;
        here_row = i;
        here_col = j;
        here_vtx = v;
        if (i >= 1) begin
            res[n] = normal_of(i - 1, j, dx, dy);
            n++;
            if (j >= 1) begin
                res[n] = triangle_of((i - 1) * dy + j - 1, (i - 1) * dy + j,
                                     i * dy + j - 1);
                n++;
                res[n] = triangle_of(i * dy + j, (i - 1) * dy + j, i * dy + j - 1);
                n++;
            end
            if (i + 1 == dx) begin
                if (j >= 1) begin
                    res[n] = normal_of(i, j - 1, dx, dy);
                    n++;
                end
                if (j + 1 == dy) begin
                    res[n] = normal_of(i, j, dx, dy);
                    n++;
                end
            end
        end
        if (n > 0) res[n - 1].last = 1'b1;
        for (int k = 0; k < n; k++) results_due.insert(results_due.size(), res[k]);
        row_mem[i % 2][j % GRID_COLS] = v;
        next_col = j + 1;
        if (next_col >= dy) begin
            next_col = 0;
            next_row = i + 1;
            if (next_row >= dx) next_row = 0;
        end
    endfunction

    function automatic bit field_differs(string name, logic [63:0] exp_v,
                                         logic [63:0] act_v);
        if (exp_v === act_v) return 1'b0;
        if (mismatch_count < 10)
            $display("result %0d, %s: expected %h, got %h", results_seen, name,
                     exp_v, act_v);
        return 1'b1;
    endfunction

    function automatic int unsigned idle_gap(int unsigned level);
        int unsigned r;
        if (level == 0) return 0;
        r = $urandom_range(0, 99);
        if (level == 1) return (r < 80) ? 0 : $urandom_range(1, 3);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 4);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2, 3: return COORD_W'(int'($urandom_range(0, 64)) - 32);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic in_beat_t random_vertex();
        in_beat_t v;
        v.vx = pick_coord();
        v.vy = pick_coord();
        v.vz = pick_coord();
        return v;
    endfunction

    // each coordinate at one end of its range, picked by a bit of k
    function automatic in_beat_t corner_vertex(int unsigned k);
        in_beat_t v;
        v.vx = (k & 1) ? 16'h8000 : 16'h7FFF;
        v.vy = (k & 2) ? 16'h8000 : 16'h7FFF;
        v.vz = (k & 4) ? 16'h8000 : 16'h7FFF;
        return v;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 11))
            0: return DIM_W'($urandom_range(0, 1));
            1: return DIM_W'(2);
            2: return DIM_W'($urandom_range(257, 511));
            3: return DIM_W'(256);
            default: return DIM_W'($urandom_range(2, 6));
        endcase
    endfunction

    // sender: one beat held until taken, then a random gap
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            src_wait <= 0;
        end else if (!s_valid || s_ready) begin
            if (src_wait > 0) begin
                s_valid  <= 1'b0;
                src_wait <= src_wait - 1;
            end else if (vertices_to_send.size() > 0) begin
                s_data   <= vertices_to_send.pop_front();
                s_valid  <= 1'b1;
                src_wait <= idle_gap(src_level);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_wait <= 0;
            hold_done <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            sink_wait <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (sink_wait > 0) begin
            sink_wait <= sink_wait - 1;
            m_ready   <= 1'b0;
        end else begin
            sink_gap = idle_gap(sink_level);
            if (sink_gap == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready   <= 1'b0;
                sink_wait <= sink_gap - 1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_vertex(s_data);
                vertices_taken++;
            end
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("result %0d arrived with nothing expected: %h",
                                 results_seen, m_data);
                    mismatch_count++;
                end else begin
                    want = results_due.pop_front();
                    beat_bad = 1'b0;
                    beat_bad |= field_differs("kind", 64'(want.kind), 64'(m_data.kind));
                    beat_bad |= field_differs("nx", 64'(want.nx), 64'(m_data.nx));
                    beat_bad |= field_differs("ny", 64'(want.ny), 64'(m_data.ny));
                    beat_bad |= field_differs("nz", 64'(want.nz), 64'(m_data.nz));
                    beat_bad |= field_differs("vertex_index", 64'(want.vertex_index),
                                              64'(m_data.vertex_index));
                    beat_bad |= field_differs("corner_a", 64'(want.corner_a),
                                              64'(m_data.corner_a));
                    beat_bad |= field_differs("corner_b", 64'(want.corner_b),
                                              64'(m_data.corner_b));
                    beat_bad |= field_differs("corner_c", 64'(want.corner_c),
                                              64'(m_data.corner_c));
                    beat_bad |= field_differs("last", 64'(want.last), 64'(m_data.last));
                    if (beat_bad) mismatch_count++;
                    if (want.kind == KIND_TRIANGLE) tri_count++;
                    else normal_count++;
                end
                results_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count,
                     results_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    // first-row vertices give no result, so wait out the pipeline too
    task automatic settle();
        while (vertices_to_send.size() != 0 || s_valid || results_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [DIM_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_DIM_X) dim_x_reg = val;
        else dim_y_reg = val;
        next_row = 0;
        next_col = 0;
    endtask

    task automatic set_grid(logic [DIM_W-1:0] dx, logic [DIM_W-1:0] dy, bit wr_x,
                            bit wr_y);
        settle();
        if (wr_x) write_reg(REG_DIM_X, dx);
        if (wr_y) write_reg(REG_DIM_Y, dy);
        grid_settings++;
    endtask

    task automatic set_pace(int unsigned src_lv, int unsigned sink_lv);
        @(posedge aclk);
        src_level  <= src_lv;
        sink_level <= sink_lv;
    endtask

    task automatic send_random(int unsigned count);
        for (int k = 0; k < count; k++)
            vertices_to_send.insert(vertices_to_send.size(), random_vertex());
        random_sent += count;
    endtask

    initial begin
        logic [DIM_W-1:0] dx, dy;
        int unsigned      cells, items, pick;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: a few vertices on the default 16x16 grid first
        set_pace(0, 0);
        for (int k = 0; k < 4; k++)
            vertices_to_send.insert(vertices_to_send.size(), corner_vertex(k));

        // sizes below 2 clamp to a 2x2 grid; two grids to see the wrap
        set_grid(DIM_W'(0), DIM_W'(1), 1'b1, 1'b1);
        for (int k = 0; k < 8; k++)
            vertices_to_send.insert(vertices_to_send.size(), corner_vertex(k));

        // 3x3 with full-swing and repeated vertices, left partial at the end
        set_grid(DIM_W'(3), DIM_W'(3), 1'b1, 1'b1);
        for (int k = 0; k < 11; k++) begin
            if (k == 4 || k == 5) vertices_to_send.insert(vertices_to_send.size(), '0);
            else vertices_to_send.insert(vertices_to_send.size(), corner_vertex(k * 3 + 1));
        end

        while (random_sent < RANDOM_ITEMS) begin
            dx = pick_dim();
            dy = pick_dim();
            pick = $urandom_range(0, 3);
            set_grid(dx, dy, pick != 1, pick != 0);
            cells = span(dim_x_reg, GRID_ROWS) * span(dim_y_reg, GRID_COLS);
            if (cells <= 12)
                items = cells + $urandom_range(1, cells);
            else
                items = $urandom_range(3, 8);
            set_pace($urandom_range(0, 2), $urandom_range(0, 2));
            send_random(items);
        end

        // widest rows (511 clamps to 256) through to the last row, under a
        // long output hold-off while the sender keeps going
        set_grid(DIM_W'(2), DIM_W'(511), 1'b1, 1'b1);
        set_pace(0, 1);
        hold_req <= 1'b1;
        send_random(264);

        set_grid(DIM_W'(256), DIM_W'(2), 1'b1, 1'b1);
        set_pace(2, 2);
        send_random(10);

        settle();
        $display("%0d vertices over %0d grid settings; %0d normals, %0d triangles checked",
                 vertices_taken, grid_settings, normal_count, tri_count);
        $display("covered clamped and maximum sizes, grid wrap, restarts and a %0d-cycle stall",
                 HOLD_CYCLES);
        if (mismatch_count == 0 && results_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d bad result beats, %0d still due", mismatch_count,
                     results_due.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/gmng_pkg.sv
hdl/gmng_cross.sv
hdl/grid_mesh_normal_generator.sv
tb/tb.sv
